>>> rtl/rtsd_pkg.sv
// Shared types and constants of the record table search and delete block.
package rtsd_pkg;

    localparam int ENTRIES = 64;
    localparam int IDX_W   = 6;
    localparam int CNT_W   = 7;
    localparam int DATA_W  = 16;
    localparam int GROUP   = 8;
    localparam int OFF_W   = 3;
    localparam int GROUPS  = ENTRIES / GROUP;

    localparam logic [1:0] ACT_WRITE  = 2'd0;
    localparam logic [1:0] ACT_SEARCH = 2'd1;
    localparam logic [1:0] ACT_DELETE = 2'd2;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_BAD  = 2'd2;

    typedef struct packed {
        logic [DATA_W-1:0] key;
        logic [DATA_W-1:0] name_ref;
        logic [DATA_W-1:0] kana_ref;
    } rec_t;

    // Broadcast from the controller to every cell.
    typedef struct packed {
        logic             wr;
        logic             cmp;
        logic             by_key;
        logic             shift;
        logic [IDX_W-1:0] idx;
        logic [CNT_W-1:0] count;
        rec_t             wrec;
    } cell_ctrl_t;

endpackage

>>> rtl/rtsd_cell.sv
// One table cell: holds a record, compares it and takes its neighbor's record on a shift.
module rtsd_cell (
    input  logic                      clk,
    input  rtsd_pkg::cell_ctrl_t      ctrl,
    input  logic [rtsd_pkg::IDX_W-1:0] my_index,
    input  rtsd_pkg::rec_t            next_rec,
    output rtsd_pkg::rec_t            rec,
    output logic                      sel
);
    import rtsd_pkg::*;

    rec_t rec_reg;
    logic sel_reg;
    logic at_me;
    logic in_table;

    assign at_me    = (my_index == ctrl.idx);
    assign in_table = ({1'b0, my_index} < ctrl.count);

    // Writes and shifts come from different controller states, so they never coincide.
    always_ff @(posedge clk)
    begin
        if (ctrl.wr && at_me)
        begin
            rec_reg <= ctrl.wrec;
        end
        else if (ctrl.shift && (my_index >= ctrl.idx))
        begin
            rec_reg <= next_rec;
        end
    end

    // A search marks valid cells with a matching key; other actions mark the indexed cell.
    always_ff @(posedge clk)
    begin
        if (ctrl.cmp)
        begin
            sel_reg <= ctrl.by_key ? (in_table && (rec_reg.key == ctrl.wrec.key)) : at_me;
        end
    end

    assign rec = rec_reg;
    assign sel = sel_reg;

endmodule

>>> rtl/rtsd_pick.sv
// First-marked selector over one group of records.
module rtsd_pick (
    input  logic [rtsd_pkg::GROUP-1:0] sel,
    input  rtsd_pkg::rec_t             recs [rtsd_pkg::GROUP],
    output logic                       hit,
    output logic [rtsd_pkg::OFF_W-1:0] off,
    output rtsd_pkg::rec_t             rec
);
    import rtsd_pkg::*;

    always_comb
    begin
        hit = |sel;
        off = '0;
        rec = '0;
        for (int i = GROUP - 1; i >= 0; i--)
        begin
            if (sel[i])
            begin
                off = OFF_W'(i);
                rec = recs[i];
            end
        end
    end

endmodule

>>> rtl/record_table_search_delete.sv
// An accepted input word passes the cell compare, group and result registers in turn;
// the result register loads once it is free, and only then does the block go back to
// idle and take the next word, so a new word is not taken while one is in flight.
// Deletes shift all later cells down one place together.
// Reset clears the record count, FSM state and out_valid; record contents stay undefined.
// The result register lets a new word be accepted while a result waits.
module record_table_search_delete (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [1:0]                  action,
    input  logic [rtsd_pkg::IDX_W-1:0]  index,
    input  logic [rtsd_pkg::DATA_W-1:0] key,
    input  logic [rtsd_pkg::DATA_W-1:0] name_ref,
    input  logic [rtsd_pkg::DATA_W-1:0] kana_ref,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [1:0]                  status,
    output logic [rtsd_pkg::CNT_W-1:0]  found_index,
    output logic [rtsd_pkg::DATA_W-1:0] found_key,
    output logic [rtsd_pkg::DATA_W-1:0] found_name_ref,
    output logic [rtsd_pkg::DATA_W-1:0] found_kana_ref,
    output logic [rtsd_pkg::CNT_W-1:0]  record_count
);
    import rtsd_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_CMP  = 4'b0010,
        S_GRP  = 4'b0100,
        S_FIN  = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [1:0]       act_reg;
    logic [IDX_W-1:0] idx_reg;
    rec_t             wrec_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             wr_ok_reg;
    logic             wr_ok;
    logic             del_ok;
    logic             fin_go;

    cell_ctrl_t ctrl;
    rec_t       cell_rec [ENTRIES];
    logic [ENTRIES-1:0] cell_sel;

    logic             grp_hit [GROUPS];
    logic [OFF_W-1:0] grp_off [GROUPS];
    rec_t             grp_rec [GROUPS];
    logic             grp_hit_reg [GROUPS];
    logic [OFF_W-1:0] grp_off_reg [GROUPS];
    rec_t             grp_rec_reg [GROUPS];

    logic [GROUP-1:0] fin_sel;
    rec_t             fin_recs [GROUP];
    logic             fin_hit;
    logic [OFF_W-1:0] fin_grp;
    rec_t             fin_rec;

    logic             out_valid_reg, out_valid_next;
    logic [1:0]       status_reg, status_next;
    logic [CNT_W-1:0] found_index_reg, found_index_next;
    rec_t             found_rec_reg, found_rec_next;
    logic [CNT_W-1:0] record_count_reg;

    assign wr_ok  = ({1'b0, idx_reg} < count_reg) ||
                    (({1'b0, idx_reg} == count_reg) && (count_reg < CNT_W'(ENTRIES)));
    assign del_ok = ({1'b0, idx_reg} < count_reg);
    assign fin_go = !out_valid_reg || !out_stall;

    always_comb
    begin
        ctrl.wr     = (state_reg == S_CMP) && (act_reg == ACT_WRITE) && wr_ok;
        ctrl.cmp    = (state_reg == S_CMP);
        ctrl.by_key = (act_reg == ACT_SEARCH);
        ctrl.shift  = (state_reg == S_FIN) && fin_go && (act_reg == ACT_DELETE) && del_ok;
        ctrl.idx    = idx_reg;
        ctrl.count  = count_reg;
        ctrl.wrec   = wrec_reg;
    end

    genvar gi;
    generate
        for (gi = 0; gi < ENTRIES; gi++)
        begin : g_cell
            rec_t nxt;
            if (gi == ENTRIES - 1)
            begin : g_last
                assign nxt = '0;
            end
            else
            begin : g_mid
                assign nxt = cell_rec[gi + 1];
            end
            rtsd_cell u_cell (
                .clk      (clk),
                .ctrl     (ctrl),
                .my_index (IDX_W'(gi)),
                .next_rec (nxt),
                .rec      (cell_rec[gi]),
                .sel      (cell_sel[gi])
            );
        end

        for (gi = 0; gi < GROUPS; gi++)
        begin : g_grp
            rec_t recs [GROUP];
            for (genvar j = 0; j < GROUP; j++)
            begin : g_map
                assign recs[j] = cell_rec[gi * GROUP + j];
            end
            rtsd_pick u_pick (
                .sel  (cell_sel[gi * GROUP +: GROUP]),
                .recs (recs),
                .hit  (grp_hit[gi]),
                .off  (grp_off[gi]),
                .rec  (grp_rec[gi])
            );
            always_ff @(posedge clk)
            begin
                grp_hit_reg[gi] <= grp_hit[gi];
                grp_off_reg[gi] <= grp_off[gi];
                grp_rec_reg[gi] <= grp_rec[gi];
            end
        end

        for (gi = 0; gi < GROUP; gi++)
        begin : g_fin
            if (gi < GROUPS)
            begin : g_used
                assign fin_sel[gi]  = grp_hit_reg[gi];
                assign fin_recs[gi] = grp_rec_reg[gi];
            end
            else
            begin : g_pad
                assign fin_sel[gi]  = 1'b0;
                assign fin_recs[gi] = '0;
            end
        end
    endgenerate

    rtsd_pick u_fin_pick (
        .sel  (fin_sel),
        .recs (fin_recs),
        .hit  (fin_hit),
        .off  (fin_grp),
        .rec  (fin_rec)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (in_valid) state_next = S_CMP;
            S_CMP:  state_next = S_GRP;
            S_GRP:  state_next = S_FIN;
            S_FIN:  if (fin_go) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        count_next = count_reg;
        if (ctrl.wr && ({1'b0, idx_reg} == count_reg))
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (ctrl.shift)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if ((state_reg == S_FIN) && fin_go)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Input word capture, and the write check registered in the compare state.
    always_ff @(posedge clk)
    begin
        if ((state_reg == S_IDLE) && in_valid)
        begin
            act_reg           <= action;
            idx_reg           <= index;
            wrec_reg.key      <= key;
            wrec_reg.name_ref <= name_ref;
            wrec_reg.kana_ref <= kana_ref;
        end
        if (state_reg == S_CMP)
        begin
            wr_ok_reg <= wr_ok;
        end
    end

    always_comb
    begin
        status_next      = ST_BAD;
        found_index_next = '0;
        found_rec_next   = '0;
        unique case (act_reg)
            ACT_WRITE:
            begin
                if (wr_ok_reg)
                begin
                    status_next      = ST_OK;
                    found_index_next = {1'b0, idx_reg};
                end
            end
            ACT_SEARCH:
            begin
                if (fin_hit)
                begin
                    status_next      = ST_OK;
                    found_index_next = CNT_W'({fin_grp, grp_off_reg[fin_grp]});
                    found_rec_next   = fin_rec;
                end
                else
                begin
                    status_next      = ST_MISS;
                    found_index_next = count_reg;
                end
            end
            ACT_DELETE:
            begin
                if (del_ok)
                begin
                    status_next      = ST_OK;
                    found_index_next = {1'b0, idx_reg};
                    found_rec_next   = fin_rec;
                end
            end
            default:
            begin
                status_next = ST_BAD;
            end
        endcase
    end

    // Result word, loaded once the output register is free.
    always_ff @(posedge clk)
    begin
        if ((state_reg == S_FIN) && fin_go)
        begin
            record_count_reg <= count_next;
            status_reg       <= status_next;
            found_index_reg  <= found_index_next;
            found_rec_reg    <= found_rec_next;
        end
    end

    assign in_stall       = (state_reg != S_IDLE);
    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign found_index    = found_index_reg;
    assign found_key      = found_rec_reg.key;
    assign found_name_ref = found_rec_reg.name_ref;
    assign found_kana_ref = found_rec_reg.kana_ref;
    assign record_count   = record_count_reg;

endmodule

>>> test/record_table_search_delete_tb.sv
// Self-checking testbench for the record table with search and delete-with-shift.
`timescale 1ns / 100ps

module record_table_search_delete_tb;

    import rtsd_pkg::*;

    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam int HOLD_CYCLES    = 200;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int TAIL_CYCLES    = 12;
    localparam int MAX_REPORTS    = 60;

    typedef struct packed {
        logic [1:0]        action;
        logic [IDX_W-1:0]  index;
        logic [DATA_W-1:0] key;
        logic [DATA_W-1:0] name_ref;
        logic [DATA_W-1:0] kana_ref;
    } table_op_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [CNT_W-1:0]  found_index;
        logic [DATA_W-1:0] found_key;
        logic [DATA_W-1:0] found_name_ref;
        logic [DATA_W-1:0] found_kana_ref;
        logic [CNT_W-1:0]  record_count;
    } table_result_t;

    typedef struct packed {
        logic          typed;
        table_op_t     op;
        table_result_t res;
    } directed_row_t;

    localparam table_result_t NO_RESULT = '0;

    // Rows with typed set carry a result that is plain from the table contents;
    // the others are checked against the predictor.
    localparam directed_row_t DIRECTED_ROWS [22] = '{
        '{1'b1, '{ACT_SEARCH, 6'd0, 16'h0000, 16'h0000, 16'h0000},
                '{ST_MISS, 7'd0, 16'h0000, 16'h0000, 16'h0000, 7'd0}},
        '{1'b1, '{ACT_DELETE, 6'd0, 16'h0000, 16'h0000, 16'h0000},
                '{ST_BAD, 7'd0, 16'h0000, 16'h0000, 16'h0000, 7'd0}},
        '{1'b1, '{ACT_WRITE, 6'd1, 16'h1111, 16'h2222, 16'h3333},
                '{ST_BAD, 7'd0, 16'h0000, 16'h0000, 16'h0000, 7'd0}},
        '{1'b1, '{ACT_WRITE, 6'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF},
                '{ST_OK, 7'd0, 16'h0000, 16'h0000, 16'h0000, 7'd1}},
        '{1'b0, '{ACT_WRITE, 6'd1, 16'h0000, 16'h0000, 16'h0000}, NO_RESULT},
        '{1'b0, '{ACT_WRITE, 6'd2, 16'h1234, 16'h5678, 16'h9ABC}, NO_RESULT},
        '{1'b0, '{ACT_WRITE, 6'd3, 16'hFFFF, 16'h0001, 16'h0002}, NO_RESULT},
        '{1'b1, '{ACT_SEARCH, 6'd0, 16'hFFFF, 16'h0000, 16'h0000},
                '{ST_OK, 7'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 7'd4}},
        '{1'b0, '{ACT_SEARCH, 6'd0, 16'h0000, 16'h0000, 16'h0000}, NO_RESULT},
        '{1'b1, '{ACT_SEARCH, 6'd0, 16'h5555, 16'h0000, 16'h0000},
                '{ST_MISS, 7'd4, 16'h0000, 16'h0000, 16'h0000, 7'd4}},
        '{1'b0, '{ACT_WRITE, 6'd1, 16'hAAAA, 16'h5555, 16'hAAAA}, NO_RESULT},
        '{1'b1, '{ACT_UNUSED, 6'd63, 16'hFFFF, 16'hFFFF, 16'hFFFF},
                '{ST_BAD, 7'd0, 16'h0000, 16'h0000, 16'h0000, 7'd4}},
        '{1'b1, '{ACT_DELETE, 6'd63, 16'h0000, 16'h0000, 16'h0000},
                '{ST_BAD, 7'd0, 16'h0000, 16'h0000, 16'h0000, 7'd4}},
        '{1'b1, '{ACT_WRITE, 6'd63, 16'h4321, 16'h8765, 16'hCBA9},
                '{ST_BAD, 7'd0, 16'h0000, 16'h0000, 16'h0000, 7'd4}},
        '{1'b1, '{ACT_DELETE, 6'd4, 16'h0000, 16'h0000, 16'h0000},
                '{ST_BAD, 7'd0, 16'h0000, 16'h0000, 16'h0000, 7'd4}},
        '{1'b1, '{ACT_DELETE, 6'd0, 16'h0000, 16'h0000, 16'h0000},
                '{ST_OK, 7'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 7'd3}},
        '{1'b0, '{ACT_SEARCH, 6'd0, 16'hFFFF, 16'h0000, 16'h0000}, NO_RESULT},
        '{1'b0, '{ACT_DELETE, 6'd2, 16'h0000, 16'h0000, 16'h0000}, NO_RESULT},
        '{1'b0, '{ACT_DELETE, 6'd0, 16'h0000, 16'h0000, 16'h0000}, NO_RESULT},
        '{1'b0, '{ACT_DELETE, 6'd0, 16'h0000, 16'h0000, 16'h0000}, NO_RESULT},
        '{1'b1, '{ACT_SEARCH, 6'd0, 16'h1234, 16'h0000, 16'h0000},
                '{ST_MISS, 7'd0, 16'h0000, 16'h0000, 16'h0000, 7'd0}},
        '{1'b0, '{ACT_WRITE, 6'd0, 16'h0000, 16'hFFFF, 16'h0000}, NO_RESULT}
    };

    logic              clk;
    logic              rst_n          = 1'b0;
    logic              in_valid       = 1'b0;
    logic              in_stall;
    logic [1:0]        action         = ACT_WRITE;
    logic [IDX_W-1:0]  index          = '0;
    logic [DATA_W-1:0] key            = '0;
    logic [DATA_W-1:0] name_ref       = '0;
    logic [DATA_W-1:0] kana_ref       = '0;
    logic              out_valid;
    logic              out_stall      = 1'b0;
    logic [1:0]        status;
    logic [CNT_W-1:0]  found_index;
    logic [DATA_W-1:0] found_key;
    logic [DATA_W-1:0] found_name_ref;
    logic [DATA_W-1:0] found_kana_ref;
    logic [CNT_W-1:0]  record_count;

    // Predictor copy of the table.
    logic [DATA_W-1:0] key_tab  [ENTRIES];
    logic [DATA_W-1:0] name_tab [ENTRIES];
    logic [DATA_W-1:0] kana_tab [ENTRIES];
    int                tbl_count = 0;
    bit                growing   = 1'b1;

    table_result_t pending_results [$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    bit hold_req       = 1'b0;
    int hold_left      = 0;
    int quiet_cycles   = 0;

    int n_errors  = 0;
    int n_checked = 0;
    int n_words   = 0;
    int n_writes  = 0;
    int n_searches = 0;
    int n_hits    = 0;
    int n_deletes = 0;
    int n_rejects = 0;
    int n_full    = 0;

    record_table_search_delete u_dut (.*);

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Applies one word to the predictor table and returns the result it yields.
    function automatic table_result_t table_apply(input table_op_t op);
        table_result_t res;
        int            pos;
        int            i;
        bit            hit;
        res = '0;
        pos = int'(op.index);
        hit = 1'b0;
        case (op.action)
            ACT_WRITE: begin
                if (pos < tbl_count || (pos == tbl_count && tbl_count < ENTRIES)) begin
                    key_tab[pos]  = op.key;
                    name_tab[pos] = op.name_ref;
                    kana_tab[pos] = op.kana_ref;
                    if (pos == tbl_count)
                        tbl_count++;
                    res.status      = ST_OK;
                    res.found_index = CNT_W'(pos);
                end
                else
                    res.status = ST_BAD;
            end
            ACT_SEARCH: begin
                res.status      = ST_MISS;
                res.found_index = CNT_W'(tbl_count);
                for (i = 0; i < tbl_count; i++) begin
                    if (!hit && key_tab[i] == op.key) begin
                        hit                = 1'b1;
                        res.status         = ST_OK;
                        res.found_index    = CNT_W'(i);
                        res.found_key      = key_tab[i];
                        res.found_name_ref = name_tab[i];
                        res.found_kana_ref = kana_tab[i];
                    end
                end
            end
            ACT_DELETE: begin
                if (pos < tbl_count) begin
                    res.status         = ST_OK;
                    res.found_index    = CNT_W'(pos);
                    res.found_key      = key_tab[pos];
                    res.found_name_ref = name_tab[pos];
                    res.found_kana_ref = kana_tab[pos];
                    for (i = pos; i + 1 < tbl_count; i++) begin
                        key_tab[i]  = key_tab[i + 1];
                        name_tab[i] = name_tab[i + 1];
                        kana_tab[i] = kana_tab[i + 1];
                    end
                    tbl_count--;
                end
                else
                    res.status = ST_BAD;
            end
            default: res.status = ST_BAD;
        endcase
        res.record_count = CNT_W'(tbl_count);
        return res;
    endfunction

    // Mostly well-formed traffic that swings the table between empty and full,
    // with small keys half the time so that searches see duplicates.
    function automatic table_op_t make_random_op();
        table_op_t op;
        int        roll;
        int        grow_w;
        int        shrink_w;
        roll     = int'($urandom_range(0, 99));
        grow_w   = growing ? 40 : 12;
        shrink_w = growing ? 12 : 40;
        op.action   = ACT_SEARCH;
        op.index    = IDX_W'($urandom_range(0, ENTRIES - 1));
        op.key      = $urandom_range(0, 1) ? DATA_W'($urandom_range(0, 15)) : DATA_W'($urandom);
        op.name_ref = DATA_W'($urandom);
        op.kana_ref = DATA_W'($urandom);
        if (roll < 5)
            op.action = 2'($urandom_range(0, 3));
        else if (roll < 5 + grow_w) begin
            op.action = ACT_WRITE;
            if (tbl_count < ENTRIES)
                op.index = IDX_W'(tbl_count);
        end
        else if (roll < 13 + grow_w) begin
            op.action = ACT_WRITE;
            if (tbl_count > 0)
                op.index = IDX_W'($urandom_range(0, tbl_count - 1));
        end
        else if (roll < 16 + grow_w) begin
            op.action = ACT_WRITE;
            if (tbl_count < ENTRIES - 1)
                op.index = IDX_W'($urandom_range(tbl_count + 1, ENTRIES - 1));
        end
        else if (roll < 31 + grow_w) begin
            if (tbl_count > 0)
                op.key = key_tab[$urandom_range(0, tbl_count - 1)];
        end
        else if (roll < 36 + grow_w) begin
            op.key = DATA_W'($urandom);
        end
        else if (roll < 36 + grow_w + shrink_w) begin
            op.action = ACT_DELETE;
            if (tbl_count > 0)
                op.index = IDX_W'($urandom_range(0, tbl_count - 1));
        end
        else if (roll < 39 + grow_w + shrink_w) begin
            op.action = ACT_DELETE;
            if (tbl_count < ENTRIES)
                op.index = IDX_W'($urandom_range(tbl_count, ENTRIES - 1));
        end
        return op;
    endfunction

    task automatic send_word(input table_op_t op, input logic typed, input table_result_t typed_res);
        table_result_t predicted;
        int            gap;
        gap = 0;
        while ($urandom_range(0, 99) < send_idle_pct)
            gap++;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        action   <= op.action;
        index    <= op.index;
        key      <= op.key;
        name_ref <= op.name_ref;
        kana_ref <= op.kana_ref;
        do
            @(posedge clk);
        while (in_stall);
        predicted = table_apply(op);
        pending_results.push_back(typed ? typed_res : predicted);
        n_words++;
        case (op.action)
            ACT_WRITE:  n_writes++;
            ACT_SEARCH: n_searches++;
            ACT_DELETE: n_deletes++;
            default: ;
        endcase
        if (op.action == ACT_SEARCH && predicted.status == ST_OK)
            n_hits++;
        if (predicted.status == ST_BAD)
            n_rejects++;
        if (tbl_count == ENTRIES && growing) begin
            n_full++;
            growing = 1'b0;
        end
        else if (tbl_count == 0)
            growing = 1'b1;
    endtask

    task automatic wait_for_drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results.size() != 0);
    endtask

    task automatic run_random_phase(input int idle_pct, input int stall_pct, input int words,
                                    input bit with_hold);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int n = 0; n < words; n++) begin
            // A long receiver hold while words keep coming backs up the pipeline.
            if (with_hold && n == words / 3)
                hold_req = 1'b1;
            send_word(make_random_op(), 1'b0, NO_RESULT);
        end
        wait_for_drain();
    endtask

    task automatic check_field(input string what, input logic [DATA_W-1:0] want,
                               input logic [DATA_W-1:0] got);
        if (got !== want) begin
            n_errors++;
            if (n_errors <= MAX_REPORTS)
                $display("%0t ns: %s expected %0h, got %0h", $time, what, want, got);
        end
    endtask

    always @(posedge clk) begin : result_check
        table_result_t want;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_results.size() == 0) begin
                n_errors++;
                if (n_errors <= MAX_REPORTS)
                    $display("%0t ns: result word with none expected, status %0d index %0d",
                             $time, status, found_index);
            end
            else begin
                want = pending_results.pop_front();
                n_checked++;
                check_field("status", DATA_W'(want.status), DATA_W'(status));
                check_field("found_index", DATA_W'(want.found_index), DATA_W'(found_index));
                check_field("found_key", want.found_key, found_key);
                check_field("found_name_ref", want.found_name_ref, found_name_ref);
                check_field("found_kana_ref", want.found_kana_ref, found_kana_ref);
                check_field("record_count", DATA_W'(want.record_count), DATA_W'(record_count));
            end
        end
        if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t ns: no word moved for %0d cycles, %0d results outstanding",
                     $time, quiet_cycles, pending_results.size());
            $display("end of test: mismatches");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int r = 0; r < $size(DIRECTED_ROWS); r++)
            send_word(DIRECTED_ROWS[r].op, DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].res);
        wait_for_drain();
        run_random_phase(0, 0, 310, 1'b1);
        run_random_phase(55, 0, 315, 1'b0);
        run_random_phase(0, 55, 315, 1'b0);
        run_random_phase(34, 34, 310, 1'b0);
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("Sent %0d words: %0d writes, %0d searches with %0d hits, %0d deletes, %0d rejected.",
                 n_words, n_writes, n_searches, n_hits, n_deletes, n_rejects);
        $display("Table ran full %0d times; %0d result words checked, %0d field errors.",
                 n_full, n_checked, n_errors);
        if (n_errors == 0 && pending_results.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
